// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // default limits on pattern and replacement length, in bytes
  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  // fixed widths of the register and command fields
  localparam int REG_W     = 64;
  localparam int ADDR_W    = 5;
  localparam int LEN_W     = 4;
  localparam int CMD_BYTES = 8;
  localparam int IDX_W     = $clog2(CMD_BYTES);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register indexes (byte address is 8 times the index)
  typedef enum logic [1:0] {
    REG_PATTERN  = 2'd0,
    REG_PAT_LEN  = 2'd1,
    REG_REPL     = 2'd2,
    REG_REPL_LEN = 2'd3
  } sfr_reg_idx_t;

  // live configuration, lengths already clamped to their limits
  typedef struct packed {
    logic [REG_W-1:0] pattern;
    logic [LEN_W-1:0] pat_len;
    logic [REG_W-1:0] repl;
    logic [LEN_W-1:0] repl_len;
    logic             clr;
  } sfr_cfg_t;

  // one burst of result bytes; len of zero with last set is the empty end marker
  typedef struct packed {
    logic [8*CMD_BYTES-1:0] bytes;
    logic [LEN_W-1:0]       len;
    logic                   last;
  } sfr_cmd_t;

endpackage

// ===== rtl/sfr_regs.sv =====
// ----------------------------------------------------------------------------
// sfr_regs
// APB-style register file holding pattern and replacement settings.
// ----------------------------------------------------------------------------
module sfr_regs #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [sfr_pkg::REG_W-1:0]  cfg_pwdata,
  output logic [sfr_pkg::REG_W-1:0]  cfg_prdata,
  output logic                      cfg_pready,
  output sfr_pkg::sfr_cfg_t         cfg
);
  import sfr_pkg::*;

  logic [REG_W-1:0] pattern_r;
  logic [LEN_W-1:0] pat_len_r;
  logic [REG_W-1:0] repl_r;
  logic [LEN_W-1:0] repl_len_r;
  sfr_reg_idx_t     idx;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign idx        = sfr_reg_idx_t'(cfg_paddr[ADDR_W-1:3]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r  <= '0;
      pat_len_r  <= '0;
      repl_r     <= '0;
      repl_len_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_PATTERN:  pattern_r  <= cfg_pwdata;
        REG_PAT_LEN:  pat_len_r  <= cfg_pwdata[LEN_W-1:0];
        REG_REPL:     repl_r     <= cfg_pwdata;
        REG_REPL_LEN: repl_len_r <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_PATTERN:  cfg_prdata = pattern_r;
      REG_PAT_LEN:  cfg_prdata = REG_W'(pat_len_r);
      REG_REPL:     cfg_prdata = repl_r;
      REG_REPL_LEN: cfg_prdata = REG_W'(repl_len_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // clamp lengths, flag a pattern length write so pending bytes are dropped
  always_comb begin
    cfg.pattern  = pattern_r;
    cfg.repl     = repl_r;
    cfg.pat_len  = (pat_len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_r;
    cfg.repl_len = (repl_len_r > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT)
                                                          : repl_len_r;
    cfg.clr      = wr && (idx == REG_PAT_LEN);
  end

endmodule

// ===== rtl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Accepts text beats, keeps the pending window and turns each beat that yields
// bytes or ends the text into a burst command for the back end.
// ----------------------------------------------------------------------------
module sfr_front #(
  parameter int MAX_PATTERN = sfr_pkg::DEF_MAX_PATTERN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::sfr_cfg_t cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tuser,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              push,
  output sfr_pkg::sfr_cmd_t push_cmd
);
  import sfr_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [7:0]       window_r   [MAX_PATTERN];
  logic [7:0]       window_nxt [MAX_PATTERN];
  logic [7:0]       wn         [MAX_PATTERN];
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0] cnt_n;
  logic             acc, hit, full;

  assign in_tready = !q_full;
  assign acc       = in_tvalid & in_tready;

  // window with the new byte dropped in, and pattern compare
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      wn[i] = (in_tuser && (CW'(i) == cnt_r)) ? in_tdata : window_r[i];
    end
    cnt_n = LEN_W'(cnt_r) + LEN_W'(in_tuser);
    hit   = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < cfg.pat_len) && (wn[i] != cfg.pattern[8*i +: 8])) hit = 1'b0;
    end
    full = (cfg.pat_len != '0) && (cnt_n == cfg.pat_len);
  end

  // classify the beat into a burst and next window state
  always_comb begin
    push_cmd.bytes = '0;
    for (int i = 0; i < MAX_PATTERN; i++) push_cmd.bytes[8*i +: 8] = wn[i];
    push_cmd.len  = '0;
    push_cmd.last = in_tlast;
    window_nxt    = wn;
    cnt_nxt       = CW'(cnt_n);
    if (cfg.pat_len == '0) begin
      // pass through
      push_cmd.len = cnt_n;
      cnt_nxt      = '0;
    end else if (full && hit) begin
      push_cmd.bytes = cfg.repl;
      push_cmd.len   = cfg.repl_len;
      cnt_nxt        = '0;
    end else if (in_tlast) begin
      // flush everything pending
      push_cmd.len = cnt_n;
      cnt_nxt      = '0;
    end else if (full) begin
      // window full, no match: release oldest byte
      push_cmd.len = LEN_W'(1);
      for (int i = 0; i < MAX_PATTERN - 1; i++) window_nxt[i] = wn[i + 1];
      cnt_nxt = CW'(cnt_n - LEN_W'(1));
    end
  end

  assign push = acc && ((push_cmd.len != '0) || in_tlast);

  // pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg.clr) begin
      cnt_r <= '0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (acc) begin
      window_r <= window_nxt;
    end
  end

endmodule

// ===== rtl/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfr_pkg::sfr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output sfr_pkg::sfr_cmd_t pop_cmd,
  output logic              empty
);
  import sfr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sfr_cmd_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Takes burst commands from the queue and sends them out one byte per beat.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sfr_pkg::sfr_cmd_t q_cmd,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);
  import sfr_pkg::*;

  sfr_cmd_t         cur_r;
  logic             act_r;
  logic [IDX_W-1:0] idx_r;
  logic             done, out_acc, load;

  assign out_acc = out_tvalid & out_tready;
  // final beat of the current burst (an empty marker is a single beat)
  assign done    = (cur_r.len == '0) || (LEN_W'(idx_r) == cur_r.len - LEN_W'(1));
  assign load    = !act_r || (out_acc && done);
  assign pop     = load && !q_empty;

  assign out_tvalid = act_r;
  assign out_tuser  = (cur_r.len != '0);
  assign out_tdata  = out_tuser ? cur_r.bytes[8*idx_r +: 8] : 8'd0;
  assign out_tlast  = cur_r.last && done;

  // burst control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      act_r <= !q_empty;
      idx_r <= '0;
    end else if (out_acc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // burst payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_cmd;
    end
  end

endmodule

// ===== rtl/stream_find_replace.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over byte text with an APB-style register port.
// ----------------------------------------------------------------------------
// Text enters one byte per beat and leaves with every leftmost, non-overlapping
// occurrence of the pattern (pattern_len bytes, 0 passes text through) replaced
// by replacement_len bytes of the replacement. The input takes one beat per
// cycle while the two-entry command queue has room; the output sends one byte
// per cycle while out_tready is high, so a beat that yields n bytes (a
// replacement or an end-of-text flush, up to 8) holds the output until all n
// are sent and, once the queue fills, stalls the input through in_tready. The
// first byte a beat yields is written into the command queue and then loaded
// into the back end's burst register before it is offered on the output.
// Registers: pattern_bytes at 0x00, pattern_len at 0x08, replacement_bytes at
// 0x10, replacement_len at 0x18; writing pattern_len drops pending bytes. The
// user must write registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module stream_find_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] in_byte
  input  logic                       in_tuser,   // [0] in_valid
  input  logic                       in_tlast,
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic                       out_tuser,  // [0] out_valid
  output logic                       out_tlast,
  // register port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [sfr_pkg::REG_W-1:0]  cfg_pwdata,
  output logic [sfr_pkg::REG_W-1:0]  cfg_prdata,
  output logic                       cfg_pready
);
  import sfr_pkg::*;

  sfr_cfg_t cfg;
  sfr_cmd_t push_cmd, pop_cmd;
  logic     push, pop, q_full, q_empty;

  // registers
  sfr_regs #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // window and classification
  sfr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // command queue
  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // byte serialiser
  sfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
